FILE: sv/sbd_pkg.sv
// -----------------------------------------------------------------------------
// Signal binning decimator package
// Shared widths, register indexes and item types for the binning decimator.
// -----------------------------------------------------------------------------
package sbd_pkg;

	localparam int SAMPLE_BITS    = 24;
	localparam int VALUE_BITS     = 40;
	localparam int INDEX_BITS     = 16;
	localparam int RATIO_BITS     = 24;
	localparam int DIVISOR_BITS   = 16;
	localparam int COUNT_BITS     = 32;
	localparam int CUTOFF_BITS    = 40;
	localparam int CFG_INDEX_BITS = 4;
	localparam int CFG_DATA_BITS  = 24;
	localparam int QUEUE_DEPTH    = 4;

	localparam logic [CFG_INDEX_BITS-1:0] REG_BIN_RATIO    = 4'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_AVERAGE_MODE = 4'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_AVG_DIVISOR  = 4'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_MAX_BINS     = 4'd3;

	localparam logic [RATIO_BITS-1:0]   BIN_RATIO_RESET   = 24'd256;
	localparam logic [DIVISOR_BITS-1:0] AVG_DIVISOR_RESET = 16'd1;
	localparam logic [INDEX_BITS-1:0]   MAX_BINS_RESET    = 16'hFFFF;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] sample;
		logic                          channel_start;
	} sample_item_t;

	typedef struct packed {
		logic signed [VALUE_BITS-1:0] bin_value;
		logic [INDEX_BITS-1:0]        bin_index;
	} bin_item_t;

	typedef struct packed {
		logic [RATIO_BITS-1:0]   bin_ratio;
		logic                    average_mode;
		logic [DIVISOR_BITS-1:0] avg_divisor;
		logic [INDEX_BITS-1:0]   max_bins;
	} cfg_t;

endpackage

FILE: sv/sbd_front.sv
// -----------------------------------------------------------------------------
// Binning decimator front end
// Accumulates samples, tracks the bin cutoff and pushes each closed bin while the bin index is below max_bins.
// -----------------------------------------------------------------------------
module sbd_front
	import sbd_pkg::*;
#(
	parameter int RATIO_FRAC_BITS = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         sample_valid,
	output logic         sample_stall,
	input  sample_item_t sample_item,
	input  cfg_t         cfg,
	input  logic         queue_full,
	output logic         push,
	output bin_item_t    push_item
);

	localparam int SCALED_BITS = COUNT_BITS + RATIO_FRAC_BITS;
	localparam int CMP_BITS    = (SCALED_BITS > CUTOFF_BITS) ? SCALED_BITS : CUTOFF_BITS;
	localparam logic [RATIO_BITS-1:0] ONE_SAMPLE = RATIO_BITS'(1) << RATIO_FRAC_BITS;
	localparam logic [CUTOFF_BITS-1:0] CUTOFF_RESET = (BIN_RATIO_RESET < ONE_SAMPLE) ?
		'0 : CUTOFF_BITS'(BIN_RATIO_RESET - ONE_SAMPLE);

	logic [VALUE_BITS-1:0]  sum_q, sum_base, sum_new;
	logic [COUNT_BITS-1:0]  count_q, count_base, count_new;
	logic [CUTOFF_BITS-1:0] cutoff_q, cutoff_base, cutoff_reload;
	logic [INDEX_BITS-1:0]  bins_q, bins_base;
	logic [RATIO_BITS-1:0]  eff_ratio;
	logic [CMP_BITS-1:0]    scaled;
	logic                   bin_close;
	logic                   emit;
	logic                   accept;

	assign sample_stall = queue_full;
	assign accept       = sample_valid && !sample_stall;

	always_comb begin
		eff_ratio     = (cfg.bin_ratio < ONE_SAMPLE) ? ONE_SAMPLE : cfg.bin_ratio;
		cutoff_reload = CUTOFF_BITS'(eff_ratio - ONE_SAMPLE);
		sum_base      = sample_item.channel_start ? '0 : sum_q;
		count_base    = sample_item.channel_start ? '0 : count_q;
		cutoff_base   = sample_item.channel_start ? cutoff_reload : cutoff_q;
		bins_base     = sample_item.channel_start ? '0 : bins_q;
		sum_new       = sum_base + VALUE_BITS'(sample_item.sample);
		count_new     = count_base + COUNT_BITS'(1);
		scaled        = CMP_BITS'(count_new) << RATIO_FRAC_BITS;
		bin_close     = scaled > CMP_BITS'(cutoff_base);
		emit          = bin_close && (bins_base < cfg.max_bins);
	end

	assign push                = accept && emit;
	assign push_item.bin_value = sum_new;
	assign push_item.bin_index = bins_base;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q    <= '0;
			count_q  <= '0;
			cutoff_q <= CUTOFF_RESET;
			bins_q   <= '0;
		end else if (accept) begin
			sum_q    <= bin_close ? '0 : sum_new;
			count_q  <= count_new;
			cutoff_q <= bin_close ? cutoff_base + CUTOFF_BITS'(eff_ratio) : cutoff_base;
			bins_q   <= emit ? bins_base + INDEX_BITS'(1) : bins_base;
		end
	end

endmodule

FILE: sv/sbd_queue.sv
// -----------------------------------------------------------------------------
// Binning decimator bin queue
// Short first-in first-out store of closed bins between front and back end.
// -----------------------------------------------------------------------------
module sbd_queue
	import sbd_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  bin_item_t push_item,
	input  logic      pop,
	output logic      full,
	output logic      not_empty,
	output bin_item_t head_item
);

	localparam int PTR_BITS = $clog2(QUEUE_DEPTH);

	bin_item_t             entry_q [QUEUE_DEPTH];
	logic [PTR_BITS-1:0]   wr_ptr_q;
	logic [PTR_BITS-1:0]   rd_ptr_q;
	logic [PTR_BITS:0]     fill_q;

	assign full      = (fill_q == (PTR_BITS+1)'(QUEUE_DEPTH));
	assign not_empty = (fill_q != '0);
	assign head_item = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_BITS'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_BITS'(1);
			end
			if (push && !pop) begin
				fill_q <= fill_q + (PTR_BITS+1)'(1);
			end else if (pop && !push) begin
				fill_q <= fill_q - (PTR_BITS+1)'(1);
			end
		end
	end

endmodule

FILE: sv/sbd_divider.sv
// -----------------------------------------------------------------------------
// Binning decimator divider
// Signed division by an unsigned divisor, one quotient bit per cycle,
// truncated toward zero.
// -----------------------------------------------------------------------------
module sbd_divider
	import sbd_pkg::*;
(
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic signed [VALUE_BITS-1:0] dividend,
	input  logic [DIVISOR_BITS-1:0]      divisor,
	output logic                         done,
	output logic signed [VALUE_BITS-1:0] quotient
);

	localparam int CNT_BITS = $clog2(VALUE_BITS);

	logic [VALUE_BITS-1:0]   quo_q;
	logic [DIVISOR_BITS-1:0] rem_q;
	logic [DIVISOR_BITS-1:0] div_q;
	logic [CNT_BITS-1:0]     cnt_q;
	logic                    neg_q;
	logic                    busy_q;
	logic                    done_q;
	logic [DIVISOR_BITS:0]   rem_shift;
	logic                    fits;
	logic [VALUE_BITS-1:0]   magnitude;

	always_comb begin
		magnitude = dividend[VALUE_BITS-1] ? -dividend : dividend;
		rem_shift = {rem_q, quo_q[VALUE_BITS-1]};
		fits      = rem_shift >= {1'b0, div_q};
	end

	assign done     = done_q;
	assign quotient = neg_q ? -quo_q : quo_q;

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= magnitude;
			rem_q <= '0;
			div_q <= (divisor == '0) ? DIVISOR_BITS'(1) : divisor;
			neg_q <= dividend[VALUE_BITS-1];
			cnt_q <= CNT_BITS'(VALUE_BITS - 1);
		end else if (busy_q) begin
			quo_q <= {quo_q[VALUE_BITS-2:0], fits};
			rem_q <= fits ? DIVISOR_BITS'(rem_shift - {1'b0, div_q}) : rem_shift[DIVISOR_BITS-1:0];
			cnt_q <= cnt_q - CNT_BITS'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && (cnt_q == '0);
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && (cnt_q == '0)) begin
				busy_q <= 1'b0;
			end
		end
	end

endmodule

FILE: sv/sbd_back.sv
// -----------------------------------------------------------------------------
// Binning decimator back end
// Takes closed bins from the queue, optionally averages them, and holds
// the result in the output register.
// -----------------------------------------------------------------------------
module sbd_back
	import sbd_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  logic      queue_not_empty,
	input  bin_item_t head_item,
	output logic      pop,
	output logic      bin_valid,
	input  logic      bin_stall,
	output bin_item_t bin_item
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0]                   state_q;
	logic [1:0]                   state_next;
	logic                         bin_valid_q;
	bin_item_t                    bin_item_q;
	logic [INDEX_BITS-1:0]        index_q;
	logic                         out_free;
	logic                         div_start;
	logic                         div_done;
	logic signed [VALUE_BITS-1:0] div_quotient;
	logic                         load_pass;
	logic                         load_avg;

	sbd_divider u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (head_item.bin_value),
		.divisor  (cfg.avg_divisor),
		.done     (div_done),
		.quotient (div_quotient)
	);

	assign out_free = !bin_valid_q || !bin_stall;

	always_comb begin
		state_next = state_q;
		load_pass  = 1'b0;
		load_avg   = 1'b0;
		div_start  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (queue_not_empty) begin
					if (cfg.average_mode) begin
						div_start  = 1'b1;
						state_next = ST_DIV;
					end else if (out_free) begin
						load_pass = 1'b1;
					end
				end
			end
			ST_DIV: begin
				if (div_done) begin
					state_next = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					load_avg   = 1'b1;
					state_next = ST_IDLE;
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	assign pop       = load_pass || div_start;
	assign bin_valid = bin_valid_q;
	assign bin_item  = bin_item_q;

	always_ff @(posedge clk) begin
		if (div_start) begin
			index_q <= head_item.bin_index;
		end
		if (load_pass) begin
			bin_item_q <= head_item;
		end else if (load_avg) begin
			bin_item_q.bin_value <= div_quotient;
			bin_item_q.bin_index <= index_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			bin_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (load_pass || load_avg) begin
				bin_valid_q <= 1'b1;
			end else if (!bin_stall) begin
				bin_valid_q <= 1'b0;
			end
		end
	end

endmodule

FILE: sv/signal_binning_decimator_top.sv
// -----------------------------------------------------------------------------
// Signal binning decimator
// Integrate-and-dump decimator with fractional bin widths and optional
// averaging of each bin.
//
// Samples arrive on the sample channel (sample_valid, sample_stall,
// sample_item), one item per cycle at full rate while sample_stall is low.
// A set channel_start flag clears the bin sum, sample count and bin index
// and reloads the cutoff before the sample is added. Closed bins leave on
// the bin channel (bin_valid, bin_stall, bin_item). Registers are written
// through cfg_valid, cfg_ready, cfg_index and cfg_data; the user must write
// them only while the block is idle, which the block itself does not
// enforce; cfg_ready is always high. In sum mode a closing bin passes
// through the queue and the output register. In average mode the bit-serial
// divider adds its 40 iterations, and no new bin leaves the queue until the
// last result is loaded. A four-entry queue sits between the accumulator and
// the divider; sample_stall rises only when it is full. When the receiver
// stalls, the output register holds its item, the queue fills and the sample
// channel stalls. Reset clears the control state and loads register defaults.
// -----------------------------------------------------------------------------
module signal_binning_decimator_top
	import sbd_pkg::*;
#(
	parameter int RATIO_FRAC_BITS = 8
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      sample_valid,
	output logic                      sample_stall,
	input  sample_item_t              sample_item,
	output logic                      bin_valid,
	input  logic                      bin_stall,
	output bin_item_t                 bin_item,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

	cfg_t      cfg_q;
	logic      queue_full;
	logic      queue_not_empty;
	logic      push;
	logic      pop;
	bin_item_t push_item;
	bin_item_t head_item;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bin_ratio    <= BIN_RATIO_RESET;
			cfg_q.average_mode <= 1'b0;
			cfg_q.avg_divisor  <= AVG_DIVISOR_RESET;
			cfg_q.max_bins     <= MAX_BINS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_BIN_RATIO:    cfg_q.bin_ratio    <= cfg_data[RATIO_BITS-1:0];
				REG_AVERAGE_MODE: cfg_q.average_mode <= cfg_data[0];
				REG_AVG_DIVISOR:  cfg_q.avg_divisor  <= cfg_data[DIVISOR_BITS-1:0];
				REG_MAX_BINS:     cfg_q.max_bins     <= cfg_data[INDEX_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	sbd_front #(
		.RATIO_FRAC_BITS (RATIO_FRAC_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample_item  (sample_item),
		.cfg          (cfg_q),
		.queue_full   (queue_full),
		.push         (push),
		.push_item    (push_item)
	);

	sbd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.full      (queue_full),
		.not_empty (queue_not_empty),
		.head_item (head_item)
	);

	sbd_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg_q),
		.queue_not_empty (queue_not_empty),
		.head_item       (head_item),
		.pop             (pop),
		.bin_valid       (bin_valid),
		.bin_stall       (bin_stall),
		.bin_item        (bin_item)
	);

endmodule

FILE: bench/tb_signal_binning_decimator_top.sv
// -----------------------------------------------------------------------------
// Binning decimator testbench
// Drives signed samples into the integrate-and-dump decimator, predicts every
// closed bin from a bit-accurate model of the accumulator, cutoff and divider,
// and compares each bin item as it leaves. Directed items cover the sample
// extremes, short and fractional bin widths, zero divisor, dropped bins, a
// register change in the middle of a channel and a long output hold-off;
// random phases then sweep the registers with random gaps on both channels,
// each followed by a pause until the block has drained.
// -----------------------------------------------------------------------------
module tb_signal_binning_decimator_top;
	import sbd_pkg::*;

	localparam int FRAC_BITS     = 8;
	localparam int SETTLE_CYCLES = 64;
	localparam int HOLD_CYCLES   = 300;
	localparam int CYCLE_LIMIT   = 600000;
	localparam int RANDOM_PHASES = 10;
	localparam int PHASE_ITEMS   = 90;

	localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED = 4'd14;
	localparam logic [CUTOFF_BITS-1:0]    ONE_SAMPLE = 40'd1 << FRAC_BITS;
	localparam int                        SAMPLE_MAX = (1 << (SAMPLE_BITS-1)) - 1;
	localparam int                        SAMPLE_MIN = -(1 << (SAMPLE_BITS-1));

	logic                      clk;
	logic                      arst_n       = 1'b0;
	logic                      sample_valid = 1'b0;
	logic                      sample_stall;
	sample_item_t              sample_item  = '0;
	logic                      bin_valid;
	logic                      bin_stall    = 1'b0;
	bin_item_t                 bin_item;
	logic                      cfg_valid    = 1'b0;
	logic                      cfg_ready;
	logic [CFG_INDEX_BITS-1:0] cfg_index    = '0;
	logic [CFG_DATA_BITS-1:0]  cfg_data     = '0;

	// Register copies and accumulator state of the prediction.
	logic [RATIO_BITS-1:0]   ratio_setting;
	logic                    averaging;
	logic [DIVISOR_BITS-1:0] divisor_setting;
	logic [INDEX_BITS-1:0]   bin_limit;
	logic [VALUE_BITS-1:0]   running_sum;
	logic [COUNT_BITS-1:0]   channel_samples;
	logic [CUTOFF_BITS-1:0]  cutoff_q;
	logic [INDEX_BITS-1:0]   bins_out;

	sample_item_t pending_samples[$];
	bin_item_t    expected_bins[$];
	bin_item_t    oldest_bin;

	int samples_queued = 0;
	int samples_taken  = 0;
	int send_gap       = 0;
	int recv_wait      = 0;
	int tx_gap_max     = 0;
	int rx_gap_max     = 0;
	int hold_requests  = 0;
	int hold_served    = 0;
	int hold_left      = 0;
	int mismatches     = 0;
	int cycles         = 0;
	logic stall_next;

	signal_binning_decimator_top #(
		.RATIO_FRAC_BITS(FRAC_BITS)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample_item  (sample_item),
		.bin_valid    (bin_valid),
		.bin_stall    (bin_stall),
		.bin_item     (bin_item),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [CUTOFF_BITS-1:0] bin_span();
		logic [CUTOFF_BITS-1:0] w;
		w = CUTOFF_BITS'(ratio_setting);
		if (w < ONE_SAMPLE) begin
			w = ONE_SAMPLE;
		end
		return w;
	endfunction

	function automatic void clear_channel();
		running_sum     = '0;
		channel_samples = '0;
		cutoff_q        = bin_span() - ONE_SAMPLE;
		bins_out        = '0;
	endfunction

	function automatic void apply_reg(input logic [CFG_INDEX_BITS-1:0] idx,
			input logic [CFG_DATA_BITS-1:0] data);
		case (idx)
			REG_BIN_RATIO:    ratio_setting   = data[RATIO_BITS-1:0];
			REG_AVERAGE_MODE: averaging       = data[0];
			REG_AVG_DIVISOR:  divisor_setting = data[DIVISOR_BITS-1:0];
			REG_MAX_BINS:     bin_limit       = data[INDEX_BITS-1:0];
			default: ;
		endcase
	endfunction

	function automatic void integrate_sample(input sample_item_t it);
		logic [CUTOFF_BITS-1:0] scaled;
		longint total;
		longint divisor;
		bin_item_t closed;
		if (it.channel_start) begin
			clear_channel();
		end
		running_sum     = running_sum + {{(VALUE_BITS-SAMPLE_BITS){it.sample[SAMPLE_BITS-1]}},
			it.sample};
		channel_samples = channel_samples + COUNT_BITS'(1);
		scaled          = CUTOFF_BITS'(channel_samples);
		scaled          = scaled << FRAC_BITS;
		if (scaled > cutoff_q) begin
			if (bins_out < bin_limit) begin
				total = longint'($signed(running_sum));
				if (averaging) begin
					divisor = (divisor_setting == '0) ? longint'(1) : longint'(divisor_setting);
					total   = total / divisor;
				end
				closed.bin_value = total[VALUE_BITS-1:0];
				closed.bin_index = bins_out;
				expected_bins.push_back(closed);
				bins_out = bins_out + INDEX_BITS'(1);
			end
			running_sum = '0;
			cutoff_q    = cutoff_q + bin_span();
		end
	endfunction

	function automatic int random_sample();
		case ($urandom_range(0, 15))
			0:       return SAMPLE_MAX;
			1:       return SAMPLE_MIN;
			2:       return int'($urandom_range(0, 16)) - 8;
			default: return int'($urandom());
		endcase
	endfunction

	task automatic offer(input int s, input logic start);
		sample_item_t it;
		it.sample        = SAMPLE_BITS'(s);
		it.channel_start = start;
		pending_samples.push_back(it);
		samples_queued++;
	endtask

	task automatic drain();
		do @(posedge clk);
		while (samples_taken != samples_queued || expected_bins.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input int data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= CFG_DATA_BITS'(data);
		do @(posedge clk);
		while (!cfg_ready);
		apply_reg(idx, CFG_DATA_BITS'(data));
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (sample_valid && !sample_stall) begin
				integrate_sample(sample_item);
				samples_taken++;
			end
			if (!sample_valid || !sample_stall) begin
				if (send_gap > 0) begin
					send_gap--;
					sample_valid <= 1'b0;
				end else if (pending_samples.size() != 0) begin
					sample_item  <= pending_samples.pop_front();
					sample_valid <= 1'b1;
					send_gap = $urandom_range(tx_gap_max);
				end else begin
					sample_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (bin_valid && !bin_stall) begin
				if (expected_bins.size() == 0) begin
					$error("bin item with none expected: bin_value %0d, bin_index %0d",
						bin_item.bin_value, bin_item.bin_index);
					mismatches++;
				end else begin
					oldest_bin = expected_bins.pop_front();
					if (bin_item.bin_value !== oldest_bin.bin_value) begin
						$error("bin_value: expected %0d, actual %0d",
							oldest_bin.bin_value, bin_item.bin_value);
						mismatches++;
					end
					if (bin_item.bin_index !== oldest_bin.bin_index) begin
						$error("bin_index: expected %0d, actual %0d",
							oldest_bin.bin_index, bin_item.bin_index);
						mismatches++;
					end
				end
			end
			if (hold_requests != hold_served) begin
				hold_served = hold_requests;
				hold_left   = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				stall_next = 1'b1;
			end else if (bin_valid && !bin_stall) begin
				recv_wait  = $urandom_range(rx_gap_max);
				stall_next = (recv_wait > 0);
				if (recv_wait > 0) begin
					recv_wait--;
				end
			end else if (recv_wait > 0) begin
				recv_wait--;
				stall_next = 1'b1;
			end else begin
				stall_next = 1'b0;
			end
			bin_stall <= stall_next;
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("** signal_binning_decimator_top: FAILED **");
			$finish;
		end
	end

	initial begin
		int n;
		ratio_setting   = BIN_RATIO_RESET;
		averaging       = 1'b0;
		divisor_setting = AVG_DIVISOR_RESET;
		bin_limit       = MAX_BINS_RESET;
		clear_channel();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// One-sample bins at the reset settings.
		offer(SAMPLE_MAX, 1'b1);
		offer(SAMPLE_MIN, 1'b0);
		offer('0, 1'b0);
		offer('1, 1'b0);
		offer(1, 1'b0);
		drain();

		// A zero bin width acts as one sample and a zero divisor as one.
		write_reg(REG_BIN_RATIO, '0);
		write_reg(REG_AVERAGE_MODE, 1);
		write_reg(REG_AVG_DIVISOR, '0);
		write_reg(REG_UNUSED, 'hA5A5A5);
		cfg_valid <= 1'b0;
		offer(-5, 1'b1);
		offer(7, 1'b0);
		drain();

		// Bins of two and a half samples, negative averages and a dropped bin.
		write_reg(REG_BIN_RATIO, 640);
		write_reg(REG_AVG_DIVISOR, 3);
		write_reg(REG_MAX_BINS, 2);
		cfg_valid <= 1'b0;
		offer(-4, 1'b1);
		offer(-3, 1'b0);
		offer(5, 1'b0);
		offer(5, 1'b0);
		offer(-1, 1'b0);
		offer(2, 1'b0);
		offer(2, 1'b0);
		offer(9, 1'b0);
		drain();

		// The channel carries on: the cutoff keeps its place and grows by the new width.
		write_reg(REG_BIN_RATIO, 1024);
		write_reg(REG_MAX_BINS, 'hFFFF);
		cfg_valid <= 1'b0;
		offer(6, 1'b0);
		offer(-11, 1'b0);
		offer(3, 1'b0);
		offer(SAMPLE_MIN, 1'b0);
		drain();

		// Widest bin: no bin can close within the few samples given.
		write_reg(REG_BIN_RATIO, 'hFFFFFF);
		write_reg(REG_AVG_DIVISOR, 'hFFFF);
		write_reg(REG_MAX_BINS, '0);
		cfg_valid <= 1'b0;
		tx_gap_max = 15;
		rx_gap_max = 15;
		for (n = 0; n < 24; n++) begin
			offer(random_sample(), n == 0);
		end
		drain();

		// The output is held off while samples keep coming, then the sender pauses.
		write_reg(REG_BIN_RATIO, 256);
		write_reg(REG_AVERAGE_MODE, 0);
		write_reg(REG_AVG_DIVISOR, 1);
		write_reg(REG_MAX_BINS, 'hFFFF);
		cfg_valid <= 1'b0;
		tx_gap_max = 0;
		rx_gap_max = 0;
		hold_requests++;
		for (n = 0; n < 40; n++) begin
			offer(random_sample(), n == 0);
		end
		drain();
		for (n = 0; n < 20; n++) begin
			offer(random_sample(), 1'b0);
		end
		drain();

		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			case ($urandom_range(0, 9))
				0:       write_reg(REG_BIN_RATIO, $urandom_range(0, 255));
				1:       write_reg(REG_BIN_RATIO, 256);
				2:       write_reg(REG_BIN_RATIO, 256 * $urandom_range(2, 8));
				3, 4:    write_reg(REG_BIN_RATIO, $urandom_range(1281, 3072));
				default: write_reg(REG_BIN_RATIO, $urandom_range(257, 1280));
			endcase
			write_reg(REG_AVERAGE_MODE, $urandom_range(0, 1));
			case ($urandom_range(0, 5))
				0:       write_reg(REG_AVG_DIVISOR, '0);
				1:       write_reg(REG_AVG_DIVISOR, 1);
				2:       write_reg(REG_AVG_DIVISOR, 'hFFFF);
				3:       write_reg(REG_AVG_DIVISOR, $urandom_range(0, 24'hFFFF));
				default: write_reg(REG_AVG_DIVISOR, $urandom_range(2, 20));
			endcase
			case ($urandom_range(0, 7))
				0:       write_reg(REG_MAX_BINS, '0);
				1:       write_reg(REG_MAX_BINS, $urandom_range(1, 6));
				2:       write_reg(REG_MAX_BINS, $urandom_range(0, 24'hFFFF));
				default: write_reg(REG_MAX_BINS, 'hFFFF);
			endcase
			cfg_valid <= 1'b0;
			tx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 15;
			rx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 15;
			for (n = 0; n < PHASE_ITEMS; n++) begin
				offer(random_sample(), n == 0 || $urandom_range(0, 39) == 0);
			end
			drain();
		end

		if (mismatches == 0) begin
			$display("** signal_binning_decimator_top: PASSED **");
		end else begin
			$display("** signal_binning_decimator_top: FAILED **");
		end
		$finish;
	end

endmodule

FILE: filelist.f
sv/sbd_pkg.sv
sv/sbd_front.sv
sv/sbd_queue.sv
sv/sbd_divider.sv
sv/sbd_back.sv
sv/signal_binning_decimator_top.sv
bench/tb_signal_binning_decimator_top.sv
